FILE: src/tptg_pkg.sv
// Package for the tag presence trigger guard.
// Holds the transaction payload types, configuration types, outcome codes and ID helpers.
// No dependencies.
package tptg_pkg;

    // Widths fixed by the field list.
    localparam int ID_BYTES  = 7;
    localparam int ID_BITS   = 8 * ID_BYTES;
    localparam int LEN_BITS  = 3;
    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 2;

    // Configuration register reset values.
    localparam logic [CFG_BITS-1:0] HOLD_GRACE_RST = 16'd300;
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd300;
    localparam logic [CFG_BITS-1:0] PREEMPT_RST    = 16'd350;

    // Configuration register indexes.
    typedef enum logic [IDX_BITS-1:0] {
        CFG_HOLD_GRACE = 2'd0,
        CFG_DEBOUNCE   = 2'd1,
        CFG_PREEMPT    = 2'd2
    } cfg_index_t;

    // Decision outcome codes.
    typedef enum logic [2:0] {
        OUT_NONE         = 3'd0,
        OUT_FIRED        = 3'd1,
        OUT_PREEMPT      = 3'd2,
        OUT_SAME_BUSY    = 3'd3,
        OUT_GAP_BLOCKED  = 3'd4,
        OUT_BUSY_NO_ID   = 3'd5,
        OUT_DEBOUNCED    = 3'd6,
        OUT_GRACE_RISE   = 3'd7
    } outcome_t;

    typedef logic [TIME_BITS-1:0]         time_t;
    typedef logic [LEN_BITS+ID_BITS-1:0]  id_t;

    // Input transaction payload.
    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic                 raw_present;
        logic [ID_BITS-1:0]   tag_id;
        logic [LEN_BITS-1:0]  tag_id_len;
        logic                 effect_idle;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic     present;
        logic     active;
        logic     wake;
        outcome_t outcome;
    } out_item_t;

    // Live configuration values.
    typedef struct packed {
        logic [CFG_BITS-1:0] grace_ms;
        logic [CFG_BITS-1:0] rearm_ms;
        logic [CFG_BITS-1:0] preempt_gap_ms;
    } cfg_t;

    // Builds the comparable ID word: length on top, bytes beyond the length zeroed.
    function automatic id_t make_id(input logic [ID_BITS-1:0] bytes,
                                    input logic [LEN_BITS-1:0] len);
        logic [ID_BITS-1:0] masked;
        masked = '0;
        for (int i = 0; i < ID_BYTES; i++) begin
            if (i < int'(len)) begin
                masked[8*i +: 8] = bytes[8*i +: 8];
            end
        end
        return {len, masked};
    endfunction

    // Wrapping time difference a - b.
    function automatic time_t time_diff(input time_t a, input time_t b);
        return a - b;
    endfunction

endpackage

FILE: src/tptg_cfg.sv
// Configuration registers of the tag presence trigger guard.
// Depends on tptg_pkg for the register indexes, reset values and cfg_t.
module tptg_cfg
    import tptg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Address decode; an index beyond the list leaves every register alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HOLD_GRACE: cfg_next.grace_ms       = cfg_data;
                CFG_DEBOUNCE:   cfg_next.rearm_ms       = cfg_data;
                CFG_PREEMPT:    cfg_next.preempt_gap_ms = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.grace_ms       <= HOLD_GRACE_RST;
            cfg_reg.rearm_ms       <= DEBOUNCE_RST;
            cfg_reg.preempt_gap_ms <= PREEMPT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/tptg_core.sv
// Decision logic and tracking state of the tag presence trigger guard.
// Depends on tptg_pkg for the payload types, outcome codes and ID helpers.
module tptg_core
    import tptg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic  prev_present_reg, prev_present_next;
    logic  hold_active_reg,  hold_active_next;
    id_t   hold_id_reg,      hold_id_next;
    id_t   busy_id_reg,      busy_id_next;
    time_t last_trigger_reg, last_trigger_next;
    time_t last_seen_reg,    last_seen_next;

    id_t      id;
    id_t      busy_eff;
    time_t    seen_gap;
    time_t    trig_gap;
    logic     raw;
    logic     idle;
    logic     present;
    logic     active;
    logic     rise;
    logic     fall;
    logic     fire;
    outcome_t outcome;

    // Graced presence and the rising-edge decision.
    always_comb
    begin
        raw      = item.raw_present;
        idle     = item.effect_idle;
        id       = make_id(item.tag_id, item.tag_id_len);
        seen_gap = time_diff(item.now_ms, last_seen_reg);
        trig_gap = time_diff(item.now_ms, last_trigger_reg);
        busy_eff = idle ? '0 : busy_id_reg;

        present = raw || (hold_active_reg &&
                          (seen_gap < TIME_BITS'(cfg.grace_ms)));
        rise    = present && !prev_present_reg;
        fall    = !present && prev_present_reg;
        active  = present;
        fire    = 1'b0;
        outcome = OUT_NONE;

        if (rise) begin
            if (!idle) begin
                // The effect unit is busy: only a fresh, different tag may preempt.
                if (!raw) begin
                    outcome = OUT_BUSY_NO_ID;
                end else if (id == busy_eff) begin
                    outcome = OUT_SAME_BUSY;
                end else if (trig_gap < TIME_BITS'(cfg.preempt_gap_ms)) begin
                    outcome = OUT_GAP_BLOCKED;
                end else begin
                    outcome = OUT_PREEMPT;
                    fire    = 1'b1;
                end
                active = fire;
            end else if (!raw) begin
                outcome = OUT_GRACE_RISE;
            end else if (hold_active_reg && (hold_id_reg == id) &&
                         (trig_gap < TIME_BITS'(cfg.rearm_ms))) begin
                outcome = OUT_DEBOUNCED;
            end else begin
                outcome = OUT_FIRED;
                fire    = 1'b1;
            end
        end

        // State update for this transaction.
        last_seen_next    = raw ? item.now_ms : last_seen_reg;
        prev_present_next = present;
        busy_id_next      = fire ? id : busy_eff;
        hold_active_next  = hold_active_reg;
        hold_id_next      = hold_id_reg;
        last_trigger_next = last_trigger_reg;
        if (fire) begin
            hold_active_next  = 1'b1;
            hold_id_next      = id;
            last_trigger_next = item.now_ms;
        end else if (fall) begin
            hold_active_next  = 1'b0;
            hold_id_next      = '0;
            last_trigger_next = '0;
        end

        result.present = present;
        result.active  = active;
        result.wake    = rise;
        result.outcome = outcome;
    end

    // Tracking state advances once per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_present_reg <= 1'b0;
            hold_active_reg  <= 1'b0;
            hold_id_reg      <= '0;
            busy_id_reg      <= '0;
            last_trigger_reg <= '0;
            last_seen_reg    <= '0;
        end else if (step) begin
            prev_present_reg <= prev_present_next;
            hold_active_reg  <= hold_active_next;
            hold_id_reg      <= hold_id_next;
            busy_id_reg      <= busy_id_next;
            last_trigger_reg <= last_trigger_next;
            last_seen_reg    <= last_seen_next;
        end
    end

endmodule

FILE: src/tag_presence_trigger_guard.sv
// Top level of the tag presence trigger guard.
// Depends on tptg_pkg, tptg_cfg and tptg_core.
//
// One input transaction per poll tick yields exactly one result transaction.
// The block takes one transaction per clock cycle while in_stall is low. An
// accepted transaction sits in the input register, the whole decision is made
// in the single combinational stage behind it, and the result is loaded into
// the result register when the input stage advances, which it does whenever
// the result register is free. While the result register is held by
// out_stall, one more input transaction can still be taken into the input
// register; after that in_stall follows out_stall.
// Configuration writes take effect on the next clock edge and should be issued
// only while no transaction is in flight.
module tag_presence_trigger_guard
    import tptg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    logic      in_valid_reg,  in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      in_take;
    logic      advance;
    cfg_t      cfg;
    out_item_t result;

    tptg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tptg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Handshake: the input stage moves on whenever the result register is free.
    always_comb
    begin
        advance  = in_valid_reg && !(out_valid_reg && out_stall);
        in_stall = in_valid_reg && !advance;
        in_take  = in_valid && !in_stall;

        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_item_reg <= in_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

FILE: src/tptg_checker.sv
// Port-level checks for the tag presence trigger guard, bound to the top level.
// Depends on tptg_pkg and tag_presence_trigger_guard.
module tptg_checker
    import tptg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed");

    // A wake implies graced presence.
    a_wake_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.wake || out_data.present))
        else $error("wake without presence");

    // An outcome is reported exactly on a rising edge.
    a_outcome_wake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.wake == (out_data.outcome != OUT_NONE)))
        else $error("outcome does not match wake");

    // Keep-alive never occurs without presence.
    a_active_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.active || out_data.present))
        else $error("active without presence");

endmodule

bind tag_presence_trigger_guard tptg_checker u_tptg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
